>>> design/aodv_route_table_engine_macros.svh
// ----------------------------------------------------------------------------
// AODV route table engine: assertion macros
// Concurrent check wrappers; empty bodies when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef AODV_ROUTE_TABLE_ENGINE_MACROS_SVH
`define AODV_ROUTE_TABLE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge out of reset
`define AODV_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("aodv check failed");
// expression must never be true out of reset
`define AODV_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("aodv forbidden condition");
`else
`define AODV_ASSERT(name, clk, rst_n, prop)
`define AODV_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

>>> design/aodvrt_pkg.sv
// ----------------------------------------------------------------------------
// AODV route table engine: shared package
// Codes, table entry layout and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package aodvrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int ADDR_BITS_DEF     = 16;
    localparam int ADDR_W            = 16;

    localparam logic [7:0] HOPS_BROKEN = 8'hFF;

    localparam logic [1:0] CMD_REQ = 2'd0;
    localparam logic [1:0] CMD_REP = 2'd1;
    localparam logic [1:0] CMD_RTO = 2'd2;
    localparam logic [1:0] CMD_LTO = 2'd3;

    localparam logic [1:0] ACT_DROP  = 2'd0;
    localparam logic [1:0] ACT_UNI   = 2'd1;
    localparam logic [1:0] ACT_BCAST = 2'd2;
    localparam logic [1:0] ACT_ABS   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] nxt;
        logic [7:0]        hops;
        logic [31:0]       seq;
        logic [31:0]       bcast;
    } t_entry;

    // result of one table scan
    typedef struct packed {
        logic   hit;
        logic   free_ok;
        t_entry ent;
    } t_scan_res;

    // table write command
    typedef struct packed {
        logic   mem_we;
        logic   set_v;
        logic   clr_v;
        t_entry ent;
    } t_wr_cmd;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] next_hop;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [31:0]       sseq;
        logic [31:0]       dseq;
        logic [31:0]       bid;
        logic [7:0]        hops;
    } t_msg;

    function automatic logic [7:0] hop_inc(input logic [7:0] h);
        return (h == HOPS_BROKEN) ? HOPS_BROKEN : h + 8'd1;
    endfunction

endpackage

`default_nettype wire

>>> design/aodv_route_table_engine.sv
// Events: one word at a time, up to three table scans per event; a new
//   word is accepted only when the sequencer is back in idle.
// The scan rate is set by the single read port of the route memory.
// Reset (synchronous, active low): table empty, node_addr 0, own_seq 1,
//   no result pending.
// ----------------------------------------------------------------------------
// AODV route table engine: top level
// Sequencer over a shared table scan unit deciding the reaction to each
// routing event (request, reply/error, reverse route timeout, link timeout).
// ----------------------------------------------------------------------------
`default_nettype none

`include "aodv_route_table_engine_macros.svh"

module aodv_route_table_engine
    import aodvrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // event words in
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [1:0]   i_cmd,
    input  wire logic [15:0]  i_from_addr,
    input  wire logic [15:0]  i_src_addr,
    input  wire logic [15:0]  i_dst_addr,
    input  wire logic [31:0]  i_src_seq,
    input  wire logic [31:0]  i_dst_seq,
    input  wire logic [31:0]  i_bcast_id,
    input  wire logic [7:0]   i_hops,
    // result words out
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [1:0]        o_action,
    output logic [15:0]       o_next_hop,
    output logic [15:0]       o_out_src_addr,
    output logic [15:0]       o_out_dst_addr,
    output logic [31:0]       o_out_src_seq,
    output logic [31:0]       o_out_dst_seq,
    output logic [31:0]       o_out_bcast_id,
    output logic [7:0]        o_out_hops
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    // only the low ADDR_BITS of an address take part
    localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((17'd1 << AW) - 17'd1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RQ_CHK,
        ST_RQ_J,
        ST_RQ_REC1,
        ST_RQ_REC2,
        ST_RP_E,
        ST_RP_BRK,
        ST_RP_MAIN,
        ST_RP_UPS,
        ST_LT_A,
        ST_LT_B,
        ST_RT,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // config registers
    logic [ADDR_W-1:0] r_node;
    logic [31:0]       r_own;

    // working copy of the message
    logic [ADDR_W-1:0] r_from, n_from;
    logic [ADDR_W-1:0] r_src, n_src;
    logic [ADDR_W-1:0] r_dst, n_dst;
    logic [31:0]       r_sseq, n_sseq;
    logic [31:0]       r_dseq, n_dseq;
    logic [31:0]       r_bid, n_bid;
    logic [7:0]        r_hops, n_hops;
    logic              r_isdest, n_isdest;

    // route kept from an earlier scan
    logic              r_e_hit, n_e_hit;
    logic [IW-1:0]     r_e_idx, n_e_idx;
    t_entry            r_e, n_e;

    // staged result and output register
    t_msg              r_p, n_p;
    t_msg              r_o, n_o;
    logic              r_ov, n_ov;

    // scan unit interface
    logic              w_scan_start;
    logic [ADDR_W-1:0] w_key;
    logic              w_scan_done;
    t_scan_res         w_res;
    logic [IW-1:0]     w_hit_idx;
    logic [IW-1:0]     w_free_idx;
    t_wr_cmd           w_wr;
    logic [IW-1:0]     w_wr_idx;

    // record_route against the latest scan of the source
    logic              w_rec_en;
    logic [IW-1:0]     w_rec_idx;
    t_entry            w_rec_ent;

    logic              w_accept;
    logic [ADDR_W-1:0] w_in_from;
    logic [ADDR_W-1:0] w_in_src;
    logic [ADDR_W-1:0] w_in_dst;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_in_from = i_from_addr & AMASK;
    assign w_in_src  = i_src_addr & AMASK;
    assign w_in_dst  = i_dst_addr & AMASK;

    assign w_rec_en  = w_res.hit || w_res.free_ok;
    assign w_rec_idx = w_res.hit ? w_hit_idx : w_free_idx;
    assign w_rec_ent = '{dest: r_src, nxt: r_from, hops: r_hops,
                         seq: r_sseq, bcast: r_bid};

    aodvrt_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan_start (w_scan_start),
        .i_key        (w_key),
        .o_scan_done  (w_scan_done),
        .o_res        (w_res),
        .o_hit_idx    (w_hit_idx),
        .o_free_idx   (w_free_idx),
        .i_wr         (w_wr),
        .i_wr_idx     (w_wr_idx)
    );

    // ---------------------------------------------------------------------
    // APB register access: node_addr at 0, own_seq at 4
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = paddr[2] ? r_own : {16'd0, r_node};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
            r_own  <= 32'd1;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_own <= pwdata;
            end else begin
                r_node <= pwdata[ADDR_W-1:0] & AMASK;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer. Each event walks a short chain of scans; a decision state
    // reads the last scan or a kept route and may kick off the next one.
    // Table writes happen only in decision states, never mid-scan.
    // ---------------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        logic       v_cond;
        logic       v_same;
        logic       v_better;
        logic       v_ok;
        logic       v_wen;
        logic [IW-1:0] v_widx;

        n_state  = r_state;
        n_ret    = r_ret;
        n_from   = r_from;
        n_src    = r_src;
        n_dst    = r_dst;
        n_sseq   = r_sseq;
        n_dseq   = r_dseq;
        n_bid    = r_bid;
        n_hops   = r_hops;
        n_isdest = r_isdest;
        n_e_hit  = r_e_hit;
        n_e_idx  = r_e_idx;
        n_e      = r_e;
        n_p      = r_p;
        n_o      = r_o;
        n_ov     = r_ov;

        w_scan_start = 1'b0;
        w_key        = '0;
        w_wr         = '0;
        w_wr_idx     = '0;

        v_cond   = 1'b0;
        v_same   = 1'b0;
        v_better = 1'b0;
        v_ok     = 1'b0;
        v_wen    = 1'b0;
        v_widx   = '0;

        if (o_out_valid && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_from   = w_in_from;
                    n_src    = w_in_src;
                    n_dst    = w_in_dst;
                    n_sseq   = i_src_seq;
                    n_dseq   = i_dst_seq;
                    n_bid    = i_bcast_id;
                    n_hops   = i_hops;
                    n_isdest = 1'b0;
                    n_state  = ST_SCAN;
                    w_scan_start = 1'b1;
                    case (i_cmd)
                        CMD_REQ: begin
                            // own request echoed back: drop at once
                            if (w_in_src == r_node) begin
                                w_scan_start = 1'b0;
                                n_p          = '0;
                                n_state      = ST_OUT;
                            end
                            w_key = w_in_src;
                            n_ret = ST_RQ_CHK;
                        end
                        CMD_REP: begin
                            w_key = w_in_dst;
                            n_ret = ST_RP_E;
                        end
                        CMD_RTO: begin
                            w_key = w_in_src;
                            n_ret = ST_RT;
                        end
                        default: begin
                            w_key = w_in_dst;
                            n_ret = ST_LT_A;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = r_ret;
                end
            end

            // --- route request ---------------------------------------
            ST_RQ_CHK: begin
                if (w_res.hit && w_res.ent.bcast == r_bid) begin
                    // duplicate broadcast
                    n_p     = '0;
                    n_state = ST_OUT;
                end else if (r_dst == r_node) begin
                    // we are the target: learn reverse route, turn round
                    w_wr.mem_we  = w_rec_en;
                    w_wr.set_v   = w_rec_en;
                    w_wr.ent     = w_rec_ent;
                    w_wr_idx     = w_rec_idx;
                    n_isdest     = 1'b1;
                    n_dst        = r_src;
                    n_src        = r_node;
                    n_hops       = 8'd1;
                    w_key        = r_src;
                    w_scan_start = 1'b1;
                    n_ret        = ST_RQ_J;
                    n_state      = ST_SCAN;
                end else begin
                    w_key        = r_dst;
                    w_scan_start = 1'b1;
                    n_ret        = ST_RQ_J;
                    n_state      = ST_SCAN;
                end
            end

            ST_RQ_J: begin
                n_e_hit = w_res.hit;
                n_e_idx = w_hit_idx;
                n_e     = w_res.ent;
                v_cond  = w_res.hit && (w_res.ent.seq >= r_dseq || r_isdest) &&
                          (w_res.ent.hops != HOPS_BROKEN);
                if (v_cond && r_dst != r_node && r_src != r_node) begin
                    // intermediate node with a fresh route: reply for it
                    w_key        = r_src;
                    w_scan_start = 1'b1;
                    n_ret        = ST_RQ_REC1;
                    n_state      = ST_SCAN;
                end else if (v_cond) begin
                    n_p.action   = ACT_UNI;
                    n_p.next_hop = w_res.ent.nxt;
                    n_p.src      = r_src;
                    n_p.dst      = r_dst;
                    n_p.sseq     = (r_dseq > r_own) ? r_dseq : r_own;
                    n_p.dseq     = r_sseq;
                    n_p.bid      = r_bid;
                    n_p.hops     = 8'd1;
                    n_state      = ST_OUT;
                end else begin
                    w_key        = r_src;
                    w_scan_start = 1'b1;
                    n_ret        = ST_RQ_REC2;
                    n_state      = ST_SCAN;
                end
            end

            ST_RQ_REC1: begin
                w_wr.mem_we = w_rec_en;
                w_wr.set_v  = w_rec_en;
                w_wr.ent    = w_rec_ent;
                w_wr_idx    = w_rec_idx;
                // source and target equal: the kept route was just rewritten
                v_same       = w_rec_en && (w_rec_idx == r_e_idx);
                n_p.action   = ACT_UNI;
                n_p.next_hop = r_from;
                n_p.src      = r_e.dest;
                n_p.dst      = r_src;
                n_p.sseq     = r_sseq;
                n_p.dseq     = v_same ? r_sseq : r_e.seq;
                n_p.bid      = r_bid;
                n_p.hops     = hop_inc(v_same ? r_hops : r_e.hops);
                n_state      = ST_OUT;
            end

            ST_RQ_REC2: begin
                w_wr.mem_we  = w_rec_en;
                w_wr.set_v   = w_rec_en;
                w_wr.ent     = w_rec_ent;
                w_wr_idx     = w_rec_idx;
                n_p.action   = ACT_BCAST;
                n_p.next_hop = '0;
                n_p.src      = r_src;
                n_p.dst      = r_dst;
                n_p.sseq     = r_sseq;
                n_p.dseq     = r_dseq;
                n_p.bid      = r_bid;
                n_p.hops     = hop_inc(r_hops);
                n_state      = ST_OUT;
            end

            // --- route reply / error ---------------------------------
            ST_RP_E: begin
                n_e_hit = w_res.hit;
                n_e_idx = w_hit_idx;
                n_e     = w_res.ent;
                if (r_hops == HOPS_BROKEN) begin
                    w_key        = r_src;
                    w_scan_start = 1'b1;
                    n_ret        = ST_RP_BRK;
                    n_state      = ST_SCAN;
                end else begin
                    n_state = ST_RP_MAIN;
                end
            end

            ST_RP_BRK: begin
                if (w_res.hit) begin
                    w_wr.mem_we   = 1'b1;
                    w_wr.ent      = w_res.ent;
                    w_wr.ent.hops = HOPS_BROKEN;
                    w_wr_idx      = w_hit_idx;
                    n_p.src       = r_src;
                    n_p.dst       = r_dst;
                    n_p.sseq      = r_sseq;
                    n_p.dseq      = r_dseq;
                    n_p.bid       = r_bid;
                    n_p.hops      = r_hops;
                    if (r_dst == r_node || !r_e_hit) begin
                        n_p.action   = ACT_ABS;
                        n_p.next_hop = '0;
                    end else begin
                        n_p.action   = ACT_UNI;
                        n_p.next_hop = r_e.nxt;
                    end
                    n_state = ST_OUT;
                end else begin
                    // unknown source: treat as ordinary reply
                    n_state = ST_RP_MAIN;
                end
            end

            ST_RP_MAIN: begin
                if (r_dst == r_node || (r_e_hit && r_e.seq >= r_dseq)) begin
                    w_key        = r_src;
                    w_scan_start = 1'b1;
                    n_ret        = ST_RP_UPS;
                    n_state      = ST_SCAN;
                end else begin
                    n_p     = '0;
                    n_state = ST_OUT;
                end
            end

            ST_RP_UPS: begin
                if (w_res.hit && w_res.ent.bcast == r_bid) begin
                    v_better = (r_dseq > w_res.ent.seq) ||
                               (r_dseq == w_res.ent.seq && w_res.ent.hops > r_hops);
                    v_ok     = v_better;
                    v_wen    = v_better;
                    v_widx   = w_hit_idx;
                    w_wr.ent = '{dest: w_res.ent.dest, nxt: r_from, hops: r_hops,
                                 seq: r_sseq, bcast: w_res.ent.bcast};
                end else begin
                    v_ok     = 1'b1;
                    v_wen    = w_rec_en;
                    v_widx   = w_rec_idx;
                    w_wr.ent = w_rec_ent;
                end
                w_wr.mem_we = v_wen;
                w_wr.set_v  = v_wen;
                w_wr_idx    = v_widx;

                n_p.src  = r_src;
                n_p.dst  = r_dst;
                n_p.sseq = r_sseq;
                n_p.dseq = r_dseq;
                n_p.bid  = r_bid;
                if (r_dst == r_node) begin
                    n_p.action   = ACT_ABS;
                    n_p.next_hop = '0;
                    n_p.hops     = r_hops;
                end else if (!v_ok) begin
                    n_p = '0;
                end else begin
                    n_p.action   = ACT_UNI;
                    n_p.next_hop = (v_wen && v_widx == r_e_idx) ? r_from : r_e.nxt;
                    n_p.hops     = hop_inc(r_hops);
                end
                n_state = ST_OUT;
            end

            // --- link timeout ----------------------------------------
            ST_LT_A: begin
                if (w_res.hit) begin
                    w_wr.mem_we   = 1'b1;
                    w_wr.ent      = w_res.ent;
                    w_wr.ent.hops = HOPS_BROKEN;
                    w_wr_idx      = w_hit_idx;
                end
                w_key        = r_src;
                w_scan_start = 1'b1;
                n_ret        = ST_LT_B;
                n_state      = ST_SCAN;
            end

            ST_LT_B: begin
                if (w_res.hit && w_res.ent.nxt != r_node) begin
                    n_p.action   = ACT_UNI;
                    n_p.next_hop = w_res.ent.nxt;
                    n_p.src      = r_dst;
                    n_p.dst      = r_src;
                    n_p.sseq     = r_sseq;
                    n_p.dseq     = r_dseq;
                    n_p.bid      = r_bid;
                    n_p.hops     = HOPS_BROKEN;
                end else begin
                    n_p = '0;
                end
                n_state = ST_OUT;
            end

            // --- reverse route timeout -------------------------------
            ST_RT: begin
                if (w_res.hit) begin
                    w_wr.clr_v = 1'b1;
                    w_wr_idx   = w_hit_idx;
                end
                n_p     = '0;
                n_state = ST_OUT;
            end

            ST_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_o     = r_p;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ov    <= n_ov;
        end
        r_from   <= n_from;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_sseq   <= n_sseq;
        r_dseq   <= n_dseq;
        r_bid    <= n_bid;
        r_hops   <= n_hops;
        r_isdest <= n_isdest;
        r_e_hit  <= n_e_hit;
        r_e_idx  <= n_e_idx;
        r_e      <= n_e;
        r_p      <= n_p;
        r_o      <= n_o;
    end

    assign o_out_valid    = r_ov;
    assign o_action       = r_o.action;
    assign o_next_hop     = r_o.next_hop;
    assign o_out_src_addr = r_o.src;
    assign o_out_dst_addr = r_o.dst;
    assign o_out_src_seq  = r_o.sseq;
    assign o_out_dst_seq  = r_o.dseq;
    assign o_out_bcast_id = r_o.bid;
    assign o_out_hops     = r_o.hops;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `AODV_ASSERT(a_done_in_scan, i_clk, i_rst_n, w_scan_done |-> r_state == ST_SCAN)
    `AODV_ASSERT_NEVER(a_no_wr_in_scan, i_clk, i_rst_n, (w_wr.mem_we || w_wr.clr_v) && r_state == ST_SCAN)
    `AODV_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept |=> r_state != ST_IDLE)

endmodule

`default_nettype wire

>>> design/aodvrt_table.sv
// ----------------------------------------------------------------------------
// AODV route table: storage and scan unit
// Route memory with valid bits; one entry compared per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aodvrt_table
    import aodvrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_scan_start,
    input  wire logic [ADDR_W-1:0]                i_key,
    output logic                                  o_scan_done,
    output t_scan_res                             o_res,
    output logic [$clog2(TABLE_ENTRIES)-1:0]      o_hit_idx,
    output logic [$clog2(TABLE_ENTRIES)-1:0]      o_free_idx,
    input  wire t_wr_cmd                          i_wr,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] i_wr_idx
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_entry                r_mem [TABLE_ENTRIES];
    t_entry                r_rd;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [ADDR_W-1:0]     r_key;
    logic                  r_hit;
    logic                  r_fok;
    logic [IW-1:0]         r_hidx;
    logic [IW-1:0]         r_fidx;
    t_entry                r_ent;

    logic [IW-1:0]         w_rd_addr;
    logic [CW-1:0]         w_cm1;
    logic [IW-1:0]         w_eidx;
    logic                  w_ev;

    assign w_rd_addr = (r_cnt < CW'(TABLE_ENTRIES)) ? r_cnt[IW-1:0] : '0;
    assign w_cm1     = r_cnt - CW'(1);
    assign w_eidx    = w_cm1[IW-1:0];
    assign w_ev      = r_valid[w_eidx];

    always_ff @(posedge i_clk) begin
        if (i_wr.mem_we) begin
            r_mem[i_wr_idx] <= i_wr.ent;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr.set_v) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_wr.clr_v) begin
                r_valid[i_wr_idx] <= 1'b0;
            end
        end
    end

    // entry read at count c is registered, then compared at index count-1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_hit  <= 1'b0;
            r_fok  <= 1'b0;
        end else if (i_scan_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_hit  <= 1'b0;
            r_fok  <= 1'b0;
            r_key  <= i_key;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                if (w_ev && r_rd.dest == r_key && !r_hit) begin
                    r_hit  <= 1'b1;
                    r_hidx <= w_eidx;
                    r_ent  <= r_rd;
                end
                if (!w_ev && !r_fok) begin
                    r_fok  <= 1'b1;
                    r_fidx <= w_eidx;
                end
            end
            if (r_cnt == CW'(TABLE_ENTRIES)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    assign o_scan_done   = r_busy && (r_cnt == CW'(TABLE_ENTRIES));
    assign o_res.hit     = r_hit;
    assign o_res.free_ok = r_fok;
    assign o_res.ent     = r_ent;
    assign o_hit_idx     = r_hidx;
    assign o_free_idx    = r_fidx;

endmodule

`default_nettype wire
